>>> src/lvdl_pkg.sv
// Package for the vibrato delay line: widths, reset values, sequencer states,
// sine quarter-wave table and control struct. No dependencies.
package lvdl_pkg;

  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned KNOB_W        = 12;
  localparam int unsigned STEP_W        = 32;
  localparam int unsigned INC_W         = 17;
  localparam int unsigned MAG1_W        = 19;
  localparam int unsigned MAG_W         = 32;
  localparam int unsigned RING_DEPTH    = 512;
  localparam int unsigned KNOB_INTERVAL = 256;

  localparam logic [STEP_W-1:0] LFO_STEP_RESET = 32'd486958;
  localparam logic [12:0]       DEPTH_GAIN     = 13'd6607;
  localparam logic [INC_W-1:0]  UNITY_INC      = 17'h10000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PTR,
    ST_RD0,
    ST_RD1,
    ST_MIX
  } lvdl_state_e;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
  } lvdl_lfo_ctl_t;

  localparam logic [6:0] QUARTER_WAVE [0:64] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
    7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
    7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
    7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
    7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
    7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
    7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
    7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd127
  };

  // Magnitude of the sine entry; the sign is bit 7 of the index.
  function automatic logic [6:0] sine_mag(input logic [7:0] idx);
    logic [6:0] k;
    logic [6:0] q;
    k = idx[6:0];
    q = (k <= 7'd64) ? k : 7'(8'd128 - {1'b0, k});
    return QUARTER_WAVE[q];
  endfunction

endpackage

>>> src/lvdl_if.sv
// Handshake channels of the vibrato delay line: sample input, output, config.
// Depends on lvdl_pkg for field widths.
interface lvdl_in_if;
  logic                            valid;
  logic                            ready;
  logic [lvdl_pkg::SAMPLE_W-1:0]   audio_sample;
  logic [lvdl_pkg::KNOB_W-1:0]     knob_level;
  modport source (output valid, output audio_sample, output knob_level, input ready);
  modport sink   (input valid, input audio_sample, input knob_level, output ready);
endinterface

interface lvdl_out_if;
  logic                            valid;
  logic                            ready;
  logic [lvdl_pkg::SAMPLE_W-1:0]   audio_out;
  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

interface lvdl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lvdl_pkg::STEP_W-1:0]     lfo_step;
  modport source (output valid, output lfo_step, input ready);
  modport sink   (input valid, input lfo_step, output ready);
endinterface

>>> src/lvdl_ring.sv
// Sample ring memory: one write port, one read port, registered read data.
// Depends on lvdl_pkg.
module lvdl_ring #(
  parameter int unsigned DEPTH = lvdl_pkg::RING_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [lvdl_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [lvdl_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [lvdl_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [lvdl_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lvdl_lfo.sv
// LFO phase, depth knob latch and two-stage wobble multiply giving the
// read pointer increment. Depends on lvdl_pkg and lvdl_cfg_if.
module lvdl_lfo #(
  parameter int unsigned KNOB_INTERVAL = lvdl_pkg::KNOB_INTERVAL,
  localparam int unsigned KCW          = $clog2(KNOB_INTERVAL + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lvdl_cfg_if.sink                      cfg_i,
  input  lvdl_pkg::lvdl_lfo_ctl_t       ctl_i,
  input  logic [lvdl_pkg::KNOB_W-1:0]   knob_i,
  output logic [lvdl_pkg::INC_W-1:0]    inc_o
);

  logic [lvdl_pkg::STEP_W-1:0] step_q;
  logic [lvdl_pkg::STEP_W-1:0] phase_q, phase_d;
  logic [KCW-1:0]              count_q, count_d, count_nx;
  logic [lvdl_pkg::KNOB_W-1:0] depth_q, depth_d;
  logic [lvdl_pkg::MAG1_W-1:0] mag1_q;
  logic [lvdl_pkg::MAG_W-1:0]  mag_q;
  logic                        neg_q;
  logic [6:0]                  smag;
  logic [lvdl_pkg::MAG_W:0]    mag_up;
  logic [15:0]                 wob;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lvdl_pkg::LFO_STEP_RESET;
    end else if (cfg_i.valid) begin
      step_q <= cfg_i.lfo_step;
    end
  end

  always_comb begin
    count_nx = count_q + 1'b1;
    count_d  = count_q;
    depth_d  = depth_q;
    phase_d  = phase_q;
    if (ctl_i.accept) begin
      phase_d = phase_q + step_q;
      if (count_nx == KCW'(KNOB_INTERVAL)) begin
        count_d = '0;
        depth_d = knob_i;
      end else begin
        count_d = count_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
      depth_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      depth_q <= depth_d;
    end
  end

  assign smag = lvdl_pkg::sine_mag(phase_q[31:24]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul1) begin
      mag1_q <= lvdl_pkg::MAG1_W'(smag) * lvdl_pkg::MAG1_W'(depth_q);
      neg_q  <= phase_q[31];
    end
    if (ctl_i.mul2) begin
      mag_q <= lvdl_pkg::MAG_W'(mag1_q) * lvdl_pkg::MAG_W'(lvdl_pkg::DEPTH_GAIN);
    end
  end

  // Negative wobble rounds toward minus infinity.
  always_comb begin
    mag_up = {1'b0, mag_q} + (lvdl_pkg::MAG_W + 1)'(neg_q ? 32'h0000_FFFF : 32'h0);
    wob    = mag_up[31:16];
    inc_o  = neg_q ? (lvdl_pkg::UNITY_INC - lvdl_pkg::INC_W'(wob))
                   : (lvdl_pkg::UNITY_INC + lvdl_pkg::INC_W'(wob));
  end

endmodule

>>> src/lfo_vibrato_delay_line_core.sv
// Top level of the vibrato delay line: sequencer, ring pointers, interpolation.
// Depends on lvdl_pkg, lvdl_if, lvdl_ring and lvdl_lfo.
//
// Channels: in_i carries audio_sample and knob_level, out_o carries audio_out,
// cfg_i writes lfo_step. Each moves one item when valid and ready are both high.
// cfg_i is always ready; write it only while no item is in flight.
// Every accepted item gives exactly one output item.
// One item is worked on at a time: in_i is not ready again until the
// sequencer has done the sample write, two multiplies, pointer update, two reads
// through the ring memory's one read port and the output mix.
// The output register parts the two sides: when the receiver stalls, the next
// item is still accepted and worked on, and the sequencer holds in its last
// step until the output register is free.
// Reset: the sequencer, pointers, LFO phase, knob counter and depth, and output
// valid return to their initial values and lfo_step to its default. The ring is
// then cleared one entry per cycle through every entry, while in_i is not ready.
module lfo_vibrato_delay_line_core #(
  parameter int unsigned RING_DEPTH    = lvdl_pkg::RING_DEPTH,
  parameter int unsigned KNOB_INTERVAL = lvdl_pkg::KNOB_INTERVAL
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lvdl_in_if.sink    in_i,
  lvdl_out_if.source out_o,
  lvdl_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned PW = AW + 16;
  localparam logic [PW:0] PTR_WRAP = (PW + 1)'(RING_DEPTH * 65536);

  lvdl_pkg::lvdl_state_e         state_q, state_d;
  lvdl_pkg::lvdl_lfo_ctl_t       lfo_ctl;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [AW-1:0]                 wpos_q, wpos_d;
  logic [PW-1:0]                 rpos_q, rpos_d;
  logic [PW:0]                   rpos_sum;
  logic [lvdl_pkg::INC_W-1:0]    inc;
  logic                          accept;
  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr, i0, i1;
  logic [lvdl_pkg::SAMPLE_W-1:0] wdata, rdata, d0_q;
  logic [lvdl_pkg::SAMPLE_W-1:0] out_q, out_d;
  logic                          out_valid_q, out_valid_d;
  logic                          load_out;
  logic [16:0]                   w0, w1;
  logic [29:0]                   acc;

  assign accept = in_i.valid && in_i.ready;
  assign i0 = rpos_q[PW-1:16];
  assign i1 = (i0 == AW'(RING_DEPTH - 1)) ? '0 : i0 + 1'b1;

  always_comb begin
    state_d       = state_q;
    in_i.ready    = 1'b0;
    lfo_ctl       = '0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = wpos_q;
    wdata         = in_i.audio_sample;
    raddr         = i0;
    clr_d         = clr_q;
    load_out      = 1'b0;
    case (state_q)
      lvdl_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(RING_DEPTH - 1)) begin
          state_d = lvdl_pkg::ST_IDLE;
        end
      end
      lvdl_pkg::ST_IDLE: begin
        in_i.ready     = 1'b1;
        lfo_ctl.accept = in_i.valid;
        we             = in_i.valid;
        if (in_i.valid) begin
          state_d = lvdl_pkg::ST_MUL1;
        end
      end
      lvdl_pkg::ST_MUL1: begin
        lfo_ctl.mul1 = 1'b1;
        state_d      = lvdl_pkg::ST_MUL2;
      end
      lvdl_pkg::ST_MUL2: begin
        lfo_ctl.mul2 = 1'b1;
        state_d      = lvdl_pkg::ST_PTR;
      end
      lvdl_pkg::ST_PTR: begin
        state_d = lvdl_pkg::ST_RD0;
      end
      lvdl_pkg::ST_RD0: begin
        re      = 1'b1;
        state_d = lvdl_pkg::ST_RD1;
      end
      lvdl_pkg::ST_RD1: begin
        re      = 1'b1;
        raddr   = i1;
        state_d = lvdl_pkg::ST_MIX;
      end
      lvdl_pkg::ST_MIX: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = lvdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lvdl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lvdl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    wpos_d = wpos_q;
    if (accept) begin
      wpos_d = (wpos_q == AW'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
    end
    rpos_sum = {1'b0, rpos_q} + (PW + 1)'(inc);
    rpos_d   = rpos_q;
    if (state_q == lvdl_pkg::ST_PTR) begin
      rpos_d = (rpos_sum >= PTR_WRAP) ? PW'(rpos_sum - PTR_WRAP) : PW'(rpos_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      wpos_q <= '0;
      rpos_q <= '0;
    end else begin
      clr_q  <= clr_d;
      wpos_q <= wpos_d;
      rpos_q <= rpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lvdl_pkg::ST_RD1) begin
      d0_q <= rdata;
    end
  end

  always_comb begin
    w1  = {1'b0, rpos_q[15:0]};
    w0  = 17'h10000 - w1;
    acc = (30'(d0_q) * 30'(w0)) + (30'(rdata) * 30'(w1));
    out_d = (acc[29:16] > 14'd4095) ? 12'hFFF : acc[27:16];
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.audio_out = out_q;

  lvdl_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lvdl_lfo #(
    .KNOB_INTERVAL (KNOB_INTERVAL)
  ) u_lfo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ctl_i  (lfo_ctl),
    .knob_i (in_i.knob_level),
    .inc_o  (inc)
  );

endmodule
